// ===== hdl/gd3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gd3_pkg
// Shared types and fixed-point constants for the 3-D Gaussian density unit.
// ----------------------------------------------------------------------------
package gd3_pkg;

  // Fixed-point formats of the datapath.
  localparam int COORD_WIDTH    = 16;
  localparam int PACK_WIDTH     = 3 * COORD_WIDTH;
  localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
  localparam int PROD_WIDTH     = COORD_WIDTH + DIFF_WIDTH;
  localparam int ROW_WIDTH      = PROD_WIDTH + 2;
  localparam int TERM_WIDTH     = DIFF_WIDTH + ROW_WIDTH;
  localparam int QUAD_WIDTH     = TERM_WIDTH + 2;
  localparam int FRAC_Q         = 24;
  localparam int EXP_ARG_RANGE  = 32;
  localparam int ARG_SHIFT      = $clog2(EXP_ARG_RANGE);
  localparam int H_WIDTH        = ARG_SHIFT + FRAC_Q;
  localparam int E_WIDTH        = 33;
  localparam int DF_WIDTH       = E_WIDTH + FRAC_Q;
  localparam int NORM_WIDTH     = 32;
  localparam int DENS_WIDTH     = 32;
  localparam int SCALE_WIDTH    = E_WIDTH + NORM_WIDTH;
  localparam int PIPE_LATENCY   = 9;

  // Configuration port.
  localparam int APB_DATA_WIDTH = 64;
  localparam int APB_ADDR_WIDTH = 5;
  localparam int REG_IDX_LSB    = 3;

  localparam logic [PACK_WIDTH-1:0] ICOV_DIAG_RESET = 48'h0100_0100_0100;
  localparam logic [NORM_WIDTH-1:0] INV_NORM_RESET  = 32'd11770;
  localparam logic [DENS_WIDTH-1:0] DENS_ONE        = 32'd1;

  typedef enum logic [1:0] {
    REG_MEAN,
    REG_ICOV_DIAG,
    REG_ICOV_OFFDIAG,
    REG_INV_NORM
  } reg_idx_t;

  typedef struct packed {
    logic [PACK_WIDTH-1:0] mean;
    logic [PACK_WIDTH-1:0] icov_diag;
    logic [PACK_WIDTH-1:0] icov_offdiag;
    logic [NORM_WIDTH-1:0] inv_norm;
  } cfg_t;

  // Half quadratic form leaving the front end.
  typedef struct packed {
    logic               valid;
    logic               oor;
    logic [H_WIDTH-1:0] h;
  } quad_res_t;

  // Interpolated exponential, Q1.32.
  typedef struct packed {
    logic               valid;
    logic               oor;
    logic [E_WIDTH-1:0] e;
  } exp_res_t;

endpackage

// ===== hdl/gd3_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gd3_cfg
// APB register file holding the mean, inverse covariance and normalization.
// ----------------------------------------------------------------------------
module gd3_cfg import gd3_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:REG_IDX_LSB]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean         <= '0;
      cfg.icov_diag    <= ICOV_DIAG_RESET;
      cfg.icov_offdiag <= '0;
      cfg.inv_norm     <= INV_NORM_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_MEAN:         cfg.mean         <= pwdata[PACK_WIDTH-1:0];
        REG_ICOV_DIAG:    cfg.icov_diag    <= pwdata[PACK_WIDTH-1:0];
        REG_ICOV_OFFDIAG: cfg.icov_offdiag <= pwdata[PACK_WIDTH-1:0];
        REG_INV_NORM:     cfg.inv_norm     <= pwdata[NORM_WIDTH-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MEAN:         prdata = APB_DATA_WIDTH'(cfg.mean);
      REG_ICOV_DIAG:    prdata = APB_DATA_WIDTH'(cfg.icov_diag);
      REG_ICOV_OFFDIAG: prdata = APB_DATA_WIDTH'(cfg.icov_offdiag);
      REG_INV_NORM:     prdata = APB_DATA_WIDTH'(cfg.inv_norm);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/gd3_quad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gd3_quad
// Four-stage front end: mean difference, matrix rows, quadratic terms, and
// the halved quadratic form with its range check.
// ----------------------------------------------------------------------------
module gd3_quad import gd3_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] sample_x,
  input  logic signed [COORD_WIDTH-1:0] sample_y,
  input  logic signed [COORD_WIDTH-1:0] sample_z,
  input  cfg_t                          cfg,
  output quad_res_t                     res
);

  logic signed [COORD_WIDTH-1:0] smp [3];
  logic signed [COORD_WIDTH-1:0] mu [3];
  logic signed [COORD_WIDTH-1:0] a [3][3];

  logic                          v1, v2, v3;
  logic signed [DIFF_WIDTH-1:0]  d1_next [3];
  logic signed [DIFF_WIDTH-1:0]  d1 [3];
  logic signed [DIFF_WIDTH-1:0]  d2 [3];
  logic signed [PROD_WIDTH-1:0]  prod [3][3];
  logic signed [ROW_WIDTH-1:0]   row_next [3];
  logic signed [ROW_WIDTH-1:0]   row [3];
  logic signed [TERM_WIDTH-1:0]  term_next [3];
  logic signed [TERM_WIDTH-1:0]  term [3];
  logic signed [QUAD_WIDTH-1:0]  qsum;
  quad_res_t                     res_next;

  assign smp[0] = sample_x;
  assign smp[1] = sample_y;
  assign smp[2] = sample_z;

  // The inverse covariance is symmetric; each off-diagonal entry is used twice.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mu[i] = cfg.mean[COORD_WIDTH*i +: COORD_WIDTH];
    end
    a[0][0] = cfg.icov_diag[0 +: COORD_WIDTH];
    a[1][1] = cfg.icov_diag[COORD_WIDTH +: COORD_WIDTH];
    a[2][2] = cfg.icov_diag[2*COORD_WIDTH +: COORD_WIDTH];
    a[0][1] = cfg.icov_offdiag[0 +: COORD_WIDTH];
    a[1][0] = cfg.icov_offdiag[0 +: COORD_WIDTH];
    a[1][2] = cfg.icov_offdiag[COORD_WIDTH +: COORD_WIDTH];
    a[2][1] = cfg.icov_offdiag[COORD_WIDTH +: COORD_WIDTH];
    a[0][2] = cfg.icov_offdiag[2*COORD_WIDTH +: COORD_WIDTH];
    a[2][0] = cfg.icov_offdiag[2*COORD_WIDTH +: COORD_WIDTH];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_next[i] = DIFF_WIDTH'(smp[i]) - DIFF_WIDTH'(mu[i]);
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = PROD_WIDTH'(a[i][j]) * PROD_WIDTH'(d1[j]);
      end
      row_next[i]  = ROW_WIDTH'(prod[i][0]) + ROW_WIDTH'(prod[i][1])
                   + ROW_WIDTH'(prod[i][2]);
      term_next[i] = TERM_WIDTH'(d2[i]) * TERM_WIDTH'(row[i]);
    end
    qsum = QUAD_WIDTH'(term[0]) + QUAD_WIDTH'(term[1]) + QUAD_WIDTH'(term[2]);

    // A negative form clamps to zero; a nonnegative one is out of range when
    // q/2 reaches the table's argument span.
    res_next.valid = v3;
    if (qsum[QUAD_WIDTH-1]) begin
      res_next.oor = 1'b0;
      res_next.h   = '0;
    end else begin
      res_next.oor = |qsum[QUAD_WIDTH-2:H_WIDTH+1];
      res_next.h   = qsum[H_WIDTH:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      res.valid <= res_next.valid;
    end
    d1      <= d1_next;
    d2      <= d1;
    row     <= row_next;
    term    <= term_next;
    res.oor <= res_next.oor;
    res.h   <= res_next.h;
  end

endmodule

// ===== hdl/gd3_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gd3_exp
// Three-stage exp(-h) evaluation: table address, table read, and linear
// interpolation between neighboring entries.
// ----------------------------------------------------------------------------
module gd3_exp import gd3_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  quad_res_t qin,
  output exp_res_t  res
);

  localparam int KW = $clog2(EXP_TABLE_ENTRIES);
  localparam int NB = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int MW = H_WIDTH + NB;

  typedef logic [E_WIDTH-1:0] exp_tab_t [0:EXP_TABLE_ENTRIES];

  // Restoring long division, used only while the table is built.
  function automatic logic [63:0] div_u64(input logic [63:0] num,
                                          input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry k holds exp(-k*R/N) in Q1.32, built by repeated multiplication by
  // exp(-R/N), which itself comes from a truncated Taylor series in Q8.56.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] base;
    logic [63:0] prev;
    term = 64'd1 << 56;
    sum  = term;
    for (int n = 1; n <= 24; n++) begin
      term = div_u64(term * 64'(EXP_ARG_RANGE), 64'(EXP_TABLE_ENTRIES) * 64'(n));
      if (n[0] == 1'b1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    base   = (sum + (64'd1 << 23)) >> 24;
    tab[0] = {1'b1, 32'd0};
    for (int k = 1; k <= EXP_TABLE_ENTRIES; k++) begin
      prev   = 64'(tab[k-1]);
      tab[k] = E_WIDTH'((prev * base + (64'd1 << 31)) >> 32);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  logic [MW-1:0]      hn;
  logic               v1, v2;
  logic               oor1, oor2;
  logic [KW-1:0]      k1;
  logic [NB-1:0]      k1_lo;
  logic [NB-1:0]      k1_hi;
  logic [FRAC_Q-1:0]  f1, f2;
  logic [E_WIDTH-1:0] tk2;
  logic [E_WIDTH-1:0] diff2;
  logic [DF_WIDTH-1:0] df;
  logic [E_WIDTH-1:0] e_next;

  // Table position is h*N/R; R is a power of two, so the divide is a shift.
  assign hn     = MW'(qin.h) * MW'(EXP_TABLE_ENTRIES);
  assign k1_lo  = NB'(k1);
  assign k1_hi  = NB'(k1) + NB'(1);
  assign df     = DF_WIDTH'(diff2) * DF_WIDTH'(f2);
  assign e_next = tk2 - df[DF_WIDTH-1:FRAC_Q];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= qin.valid;
      v2        <= v1;
      res.valid <= v2;
    end
    k1      <= hn[ARG_SHIFT+FRAC_Q +: KW];
    f1      <= hn[ARG_SHIFT +: FRAC_Q];
    oor1    <= qin.oor;
    tk2     <= EXP_TAB[k1_lo];
    diff2   <= EXP_TAB[k1_lo] - EXP_TAB[k1_hi];
    f2      <= f1;
    oor2    <= oor1;
    res.e   <= e_next;
    res.oor <= oor2;
  end

endmodule

// ===== hdl/gd3_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gd3_scale
// Scales the exponential by the reciprocal normalization and floors a zero
// or out-of-range result to one LSB.
// ----------------------------------------------------------------------------
module gd3_scale import gd3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  exp_res_t              ein,
  input  logic [NORM_WIDTH-1:0] inv_norm,
  output logic                  done,
  output logic [DENS_WIDTH-1:0] density,
  output logic                  floored
);

  logic [SCALE_WIDTH-1:0] full;
  logic                   v1;
  logic                   oor1;
  logic [DENS_WIDTH-1:0]  dens1;
  logic                   low;

  assign full = SCALE_WIDTH'(ein.e) * SCALE_WIDTH'(inv_norm);
  assign low  = oor1 | (dens1 == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= ein.valid;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    dens1   <= full[NORM_WIDTH +: DENS_WIDTH];
    oor1    <= ein.oor;
    density <= low ? DENS_ONE : dens1;
    floored <= low;
  end

endmodule

// ===== hdl/gaussian_density_3d_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_density_3d_unit
// Streaming evaluator of a 3-D Gaussian density with APB configuration.
// ----------------------------------------------------------------------------
// A sample is taken on every clock edge where start is high and busy is low,
// one per cycle, and its density comes out with a one-cycle done strobe, in
// the order the samples went in, after passing through the nine register
// stages of the pipeline: mean difference, matrix rows, quadratic terms,
// halved sum, table address, table read, interpolation, normalization
// multiply and floor. The output cannot be held off, so a result must be
// captured in its done cycle. busy is high while reset is held and is
// cleared by the first clock edge after it. The exp table holds
// EXP_TABLE_ENTRIES+1 constant entries that are computed at elaboration, so
// no fill time follows reset. Configuration must be written only while no sample is in flight.
module gaussian_density_3d_unit import gd3_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] sample_x,
  input  logic signed [COORD_WIDTH-1:0] sample_y,
  input  logic signed [COORD_WIDTH-1:0] sample_z,
  output logic                          done,
  output logic [DENS_WIDTH-1:0]         density,
  output logic                          floored,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_WIDTH-1:0]     paddr,
  input  logic [APB_DATA_WIDTH-1:0]     pwdata,
  output logic [APB_DATA_WIDTH-1:0]     prdata,
  output logic                          pready
);

  cfg_t      cfg;
  quad_res_t quad_res;
  exp_res_t  exp_res;
  logic      accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start & ~busy;

  gd3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gd3_quad u_quad (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .sample_x (sample_x),
    .sample_y (sample_y),
    .sample_z (sample_z),
    .cfg      (cfg),
    .res      (quad_res)
  );

  gd3_exp #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_exp (
    .clk (clk),
    .rst (rst),
    .qin (quad_res),
    .res (exp_res)
  );

  gd3_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .ein      (exp_res),
    .inv_norm (cfg.inv_norm),
    .done     (done),
    .density  (density),
    .floored  (floored)
  );

  // Every accepted sample produces its result at the pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LATENCY done)
    else $error("accepted sample produced no result at the pipeline latency");

  // No result appears without a matching sample accepted at the pipeline latency before it.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LATENCY))
    else $error("result strobe without a matching accepted sample");

  a_floor_value: assert property (@(posedge clk) disable iff (rst)
    (done && floored) |-> (density == DENS_ONE))
    else $error("floored result is not one LSB");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (density != '0))
    else $error("density result is zero");

endmodule
